/* src/cte_pkg.sv */
// Shared types, constants and helpers for the credential table engine.
// No dependencies; imported by every module of the block.
package cte_pkg;

    localparam int MAX_ENTRIES   = 16;
    localparam int MAX_FIELD_LEN = 255;

    localparam int SLOT_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int IDX_W   = $clog2(MAX_FIELD_LEN + 1);
    localparam int ELEN_W  = $clog2(MAX_FIELD_LEN + 1);
    localparam int LEN_W   = $clog2(MAX_FIELD_LEN + 2);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int DEPTH   = MAX_ENTRIES * MAX_FIELD_LEN;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int USER_W  = 5;
    localparam int DEF_LEN = (MAX_FIELD_LEN < 5) ? MAX_FIELD_LEN : 5;

    typedef enum logic [1:0] {
        FUNC_VALIDATE = 2'd0,
        FUNC_ADD      = 2'd1,
        FUNC_REMOVE   = 2'd2,
        FUNC_RSVD     = 2'd3
    } func_t;

    typedef struct packed {
        logic append;
        logic clr_req;
        logic slot_clr;
        logic slot_inc;
        logic j_clr;
        logic j_inc;
        logic wr_entry;
        logic commit_add;
        logic commit_remove;
    } cte_cmd_t;

    typedef struct packed {
        logic             name_ok;
        logic             pass_ok;
        logic             slot_used;
        logic             name_len_eq;
        logic             pass_len_eq;
        logic             slot_last;
        logic             j_last_name;
        logic             j_last_pass;
        logic             j_last_copy;
        logic             name_byte_eq;
        logic             pass_byte_eq;
        logic [CNT_W-1:0] count;
    } cte_status_t;

    // Factory credential held in slot 0 until that slot is first rewritten.
    function automatic logic [7:0] def_byte(input logic [IDX_W-1:0] j);
        logic [7:0] b;
        b = 8'h00;
        if (int'(j) < DEF_LEN) begin
            case (int'(j))
                0:       b = 8'h61;
                1:       b = 8'h64;
                2:       b = 8'h6d;
                3:       b = 8'h69;
                4:       b = 8'h6e;
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

/* src/cte_dp.sv */
// Datapath: request buffers, credential memories, slot metadata and counters.
// Depends on cte_pkg; driven by commands from cte_ctrl.
module cte_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cte_pkg::cte_cmd_t    cmd,
    input  logic                 in_part,
    input  logic                 in_has_byte,
    input  logic [7:0]           in_byte,
    output cte_pkg::cte_status_t status
);
    import cte_pkg::*;

    logic [7:0] ent_name_mem [DEPTH];
    logic [7:0] ent_pass_mem [DEPTH];
    logic [7:0] req_name_mem [MAX_FIELD_LEN];
    logic [7:0] req_pass_mem [MAX_FIELD_LEN];

    logic [MAX_ENTRIES-1:0] used_reg;
    logic [ELEN_W-1:0]      name_len_reg [MAX_ENTRIES];
    logic [ELEN_W-1:0]      pass_len_reg [MAX_ENTRIES];
    logic                   def_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [LEN_W-1:0]       req_name_len_reg;
    logic [LEN_W-1:0]       req_pass_len_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [IDX_W-1:0]       j_reg;

    logic [7:0] ent_name_q, ent_pass_q, req_name_q, req_pass_q, def_byte_q;
    logic       def_q;

    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  j_ext;
    logic [LEN_W-1:0]  copy_len;
    logic [7:0]        ent_name_b, ent_pass_b;

    assign addr = ADDR_W'(slot_reg) * ADDR_W'(MAX_FIELD_LEN) + ADDR_W'(j_reg);
    assign j_ext = LEN_W'(j_reg);
    assign copy_len = (req_name_len_reg > req_pass_len_reg) ? req_name_len_reg
                                                            : req_pass_len_reg;

    // Request buffers: appended on input transfers, read during the search and the copy.
    always_ff @(posedge aclk) begin
        if (cmd.append && in_has_byte) begin
            if (!in_part && req_name_len_reg < LEN_W'(MAX_FIELD_LEN))
                req_name_mem[req_name_len_reg[IDX_W-1:0]] <= in_byte;
            if (in_part && req_pass_len_reg < LEN_W'(MAX_FIELD_LEN))
                req_pass_mem[req_pass_len_reg[IDX_W-1:0]] <= in_byte;
        end
        req_name_q <= req_name_mem[j_reg];
        req_pass_q <= req_pass_mem[j_reg];
    end

    // Credential memories
    always_ff @(posedge aclk) begin
        if (cmd.wr_entry) begin
            if (j_ext < req_name_len_reg) ent_name_mem[addr] <= req_name_q;
            if (j_ext < req_pass_len_reg) ent_pass_mem[addr] <= req_pass_q;
        end
        ent_name_q <= ent_name_mem[addr];
        ent_pass_q <= ent_pass_mem[addr];
        def_byte_q <= def_byte(j_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            def_q <= 1'b0;
        end else begin
            def_q <= def_reg && (slot_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg         <= MAX_ENTRIES'(1);
            def_reg          <= 1'b1;
            cnt_reg          <= CNT_W'(1);
            req_name_len_reg <= '0;
            req_pass_len_reg <= '0;
            slot_reg         <= '0;
            j_reg            <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                name_len_reg[i] <= (i == 0) ? ELEN_W'(DEF_LEN) : '0;
                pass_len_reg[i] <= (i == 0) ? ELEN_W'(DEF_LEN) : '0;
            end
        end else begin
            if (cmd.append && in_has_byte) begin
                if (!in_part) begin
                    if (req_name_len_reg < LEN_W'(MAX_FIELD_LEN))
                        req_name_len_reg <= req_name_len_reg + 1'b1;
                    else
                        req_name_len_reg <= LEN_W'(MAX_FIELD_LEN + 1);
                end else begin
                    if (req_pass_len_reg < LEN_W'(MAX_FIELD_LEN))
                        req_pass_len_reg <= req_pass_len_reg + 1'b1;
                    else
                        req_pass_len_reg <= LEN_W'(MAX_FIELD_LEN + 1);
                end
            end
            if (cmd.clr_req) begin
                req_name_len_reg <= '0;
                req_pass_len_reg <= '0;
            end
            if (cmd.slot_clr) slot_reg <= '0;
            else if (cmd.slot_inc) slot_reg <= slot_reg + 1'b1;
            if (cmd.j_clr) j_reg <= '0;
            else if (cmd.j_inc) j_reg <= j_reg + 1'b1;
            if (cmd.commit_add) begin
                used_reg[slot_reg]     <= 1'b1;
                name_len_reg[slot_reg] <= req_name_len_reg[ELEN_W-1:0];
                pass_len_reg[slot_reg] <= req_pass_len_reg[ELEN_W-1:0];
                cnt_reg                <= cnt_reg + 1'b1;
                if (slot_reg == '0) def_reg <= 1'b0;
            end
            if (cmd.commit_remove) begin
                used_reg[slot_reg]     <= 1'b0;
                name_len_reg[slot_reg] <= '0;
                pass_len_reg[slot_reg] <= '0;
                cnt_reg                <= cnt_reg - 1'b1;
            end
        end
    end

    assign ent_name_b = def_q ? def_byte_q : ent_name_q;
    assign ent_pass_b = def_q ? def_byte_q : ent_pass_q;

    always_comb begin
        status.name_ok      = (req_name_len_reg != '0) &&
                              (req_name_len_reg <= LEN_W'(MAX_FIELD_LEN));
        status.pass_ok      = (req_pass_len_reg != '0) &&
                              (req_pass_len_reg <= LEN_W'(MAX_FIELD_LEN));
        status.slot_used    = used_reg[slot_reg];
        status.name_len_eq  = LEN_W'(name_len_reg[slot_reg]) == req_name_len_reg;
        status.pass_len_eq  = LEN_W'(pass_len_reg[slot_reg]) == req_pass_len_reg;
        status.slot_last    = slot_reg == SLOT_W'(MAX_ENTRIES - 1);
        status.j_last_name  = j_ext == req_name_len_reg - 1'b1;
        status.j_last_pass  = j_ext == req_pass_len_reg - 1'b1;
        status.j_last_copy  = j_ext == copy_len - 1'b1;
        status.name_byte_eq = ent_name_b == req_name_q;
        status.pass_byte_eq = ent_pass_b == req_pass_q;
        status.count        = cnt_reg;
    end

endmodule

/* src/cte_ctrl.sv */
// Controller FSM: gathers requests, sequences the slot search, compare and copy,
// and holds the result register. Depends on cte_pkg; commands cte_dp.
module cte_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [1:0]                 in_func,
    input  logic                       in_part,
    input  logic                       in_last,
    input  cte_pkg::cte_status_t       status,
    output cte_pkg::cte_cmd_t          cmd,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic                       out_ok,
    output logic [cte_pkg::USER_W-1:0] out_count
);
    import cte_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_START  = 13'b0000000000010,
        ST_SCAN   = 13'b0000000000100,
        ST_RDN    = 13'b0000000001000,
        ST_CMPN   = 13'b0000000010000,
        ST_NEXT   = 13'b0000000100000,
        ST_MATCH  = 13'b0000001000000,
        ST_RDP    = 13'b0000010000000,
        ST_CMPP   = 13'b0000100000000,
        ST_FREE   = 13'b0001000000000,
        ST_CPRD   = 13'b0010000000000,
        ST_CPWR   = 13'b0100000000000,
        ST_RESULT = 13'b1000000000000
    } state_t;

    state_t            state_reg, state_next;
    func_t             func_reg, func_next;
    logic              ok_reg, ok_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_ok_reg, out_ok_next;
    logic [USER_W-1:0] out_cnt_reg, out_cnt_next;
    logic              accept;
    logic              out_free;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb begin
        state_next   = state_reg;
        func_next    = func_reg;
        ok_next      = ok_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        out_ok_next  = out_ok_reg;
        out_cnt_next = out_cnt_reg;
        cmd          = '0;
        s_axis_tready = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (accept) begin
                    cmd.append = 1'b1;
                    if (in_last && (in_part || func_t'(in_func) == FUNC_REMOVE)) begin
                        func_next  = func_t'(in_func);
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                cmd.slot_clr = 1'b1;
                ok_next      = 1'b0;
                if ((func_reg == FUNC_REMOVE && status.name_ok) ||
                    ((func_reg == FUNC_VALIDATE || func_reg == FUNC_ADD) &&
                     status.name_ok && status.pass_ok))
                    state_next = ST_SCAN;
                else
                    state_next = ST_RESULT;
            end
            ST_SCAN, ST_NEXT: begin
                if (state_reg == ST_SCAN && status.slot_used && status.name_len_eq) begin
                    cmd.j_clr  = 1'b1;
                    state_next = ST_RDN;
                end else if (status.slot_last) begin
                    // name not found: only add carries on, to the free-slot search
                    if (func_reg == FUNC_ADD) begin
                        cmd.slot_clr = 1'b1;
                        state_next   = ST_FREE;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end else begin
                    cmd.slot_inc = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_RDN: state_next = ST_CMPN;
            ST_CMPN: begin
                if (!status.name_byte_eq) begin
                    state_next = ST_NEXT;
                end else if (status.j_last_name) begin
                    state_next = ST_MATCH;
                end else begin
                    cmd.j_inc  = 1'b1;
                    state_next = ST_RDN;
                end
            end
            ST_MATCH: begin
                if (func_reg == FUNC_VALIDATE && status.pass_len_eq) begin
                    cmd.j_clr  = 1'b1;
                    state_next = ST_RDP;
                end else if (func_reg == FUNC_REMOVE) begin
                    cmd.commit_remove = 1'b1;
                    ok_next           = 1'b1;
                    state_next        = ST_RESULT;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_RDP: state_next = ST_CMPP;
            ST_CMPP: begin
                if (!status.pass_byte_eq) begin
                    state_next = ST_RESULT;
                end else if (status.j_last_pass) begin
                    ok_next    = 1'b1;
                    state_next = ST_RESULT;
                end else begin
                    cmd.j_inc  = 1'b1;
                    state_next = ST_RDP;
                end
            end
            ST_FREE: begin
                if (!status.slot_used) begin
                    cmd.j_clr  = 1'b1;
                    state_next = ST_CPRD;
                end else if (status.slot_last) begin
                    state_next = ST_RESULT;
                end else begin
                    cmd.slot_inc = 1'b1;
                end
            end
            ST_CPRD: state_next = ST_CPWR;
            ST_CPWR: begin
                cmd.wr_entry = 1'b1;
                if (status.j_last_copy) begin
                    cmd.commit_add = 1'b1;
                    ok_next        = 1'b1;
                    state_next     = ST_RESULT;
                end else begin
                    cmd.j_inc  = 1'b1;
                    state_next = ST_CPRD;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    cmd.clr_req  = 1'b1;
                    m_valid_next = 1'b1;
                    out_ok_next  = ok_reg;
                    out_cnt_next = USER_W'(status.count);
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            func_reg    <= FUNC_VALIDATE;
            ok_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            func_reg    <= func_next;
            ok_reg      <= ok_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_ok_reg  <= out_ok_next;
        out_cnt_reg <= out_cnt_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign out_ok        = out_ok_reg;
    assign out_count     = out_cnt_reg;

endmodule

/* src/credential_table_engine.sv */
// Top level of the credential table engine: stream ports, controller, datapath.
// Depends on cte_pkg, cte_ctrl and cte_dp.
//
// Holds up to 16 name/password pairs (1..255 bytes each); slot 0 holds
// admin/admin after reset. Request items are taken one per cycle while no
// request is being resolved. When a request ends, the block walks the slots in
// order, comparing stored bytes against the buffered request one byte at a
// time, with a read state and a compare state per byte, through the single
// read port of each credential memory; a copy into a free slot likewise reads
// and then writes each byte. A finished result waits in the output register
// while the next request streams in.
module credential_table_engine (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
    input  logic [3:0] s_axis_tuser,  // [1:0] func, [2] part, [3] has_byte
    input  logic       s_axis_tlast,  // end_of_field
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata   // [0] ok, [5:1] user_count, [7:6] zero
);
    import cte_pkg::*;

    cte_cmd_t          cmd;
    cte_status_t       status;
    logic              out_ok;
    logic [USER_W-1:0] out_count;

    cte_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .in_func       (s_axis_tuser[1:0]),
        .in_part       (s_axis_tuser[2]),
        .in_last       (s_axis_tlast),
        .status        (status),
        .cmd           (cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .out_ok        (out_ok),
        .out_count     (out_count)
    );

    cte_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_part     (s_axis_tuser[2]),
        .in_has_byte (s_axis_tuser[3]),
        .in_byte     (s_axis_tdata),
        .status      (status)
    );

    assign m_axis_tdata = {2'b00, out_count, out_ok};

endmodule

/* src/cte_checker.sv */
// Port-level checks for credential_table_engine, attached with bind.
// Depends on cte_pkg for table size.
module cte_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    import cte_pkg::*;

    logic [USER_W-1:0] last_cnt_reg;
    logic              xfer;

    assign xfer = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) last_cnt_reg <= USER_W'(1);
        else if (xfer) last_cnt_reg <= m_axis_tdata[5:1];
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[5:1] <= USER_W'(MAX_ENTRIES))
        else $error("user count beyond table size");

    a_fail_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        xfer && !m_axis_tdata[0] |-> m_axis_tdata[5:1] == last_cnt_reg)
        else $error("failed request changed the user count");

    a_ok_step: assert property (@(posedge aclk) disable iff (!aresetn)
        xfer && m_axis_tdata[0] |->
            (m_axis_tdata[5:1] == last_cnt_reg ||
             m_axis_tdata[5:1] == last_cnt_reg + 1'b1 ||
             m_axis_tdata[5:1] == last_cnt_reg - 1'b1))
        else $error("user count moved by more than one");

endmodule

bind credential_table_engine cte_checker u_cte_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* verif/tb_top.sv */
// Self-checking bench for credential_table_engine: directed requests, then random traffic.
// Depends on cte_pkg and the credential_table_engine RTL; needs no other file.
`timescale 1ns / 100ps

module tb_top;
    import cte_pkg::*;

    typedef struct packed {
        func_t      func;
        logic       part;
        logic [7:0] data;
        logic       has_byte;
        logic       eof;
    } req_item_t;

    typedef struct packed {
        logic       ok;
        logic [4:0] count;
    } verdict_t;

    typedef struct {
        func_t func;
        string name;
        string pass;
        int    name_fill_len;   // >0 replaces name by this many copies of name_fill
        byte   name_fill;
        int    pass_fill_len;
        byte   pass_fill;
        bit    split_name;      // name sent as two field ends
        int    exp_ok;          // -1: taken from the table model
        int    exp_count;
    } dir_row_t;

    typedef byte unsigned bytes_q[$];

    logic       aclk;
    logic       aresetn;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic [3:0] s_axis_tuser;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;

    credential_table_engine u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // table model
    bit          tbl_used [MAX_ENTRIES];
    byte unsigned tbl_name [MAX_ENTRIES][MAX_FIELD_LEN];
    byte unsigned tbl_pass [MAX_ENTRIES][MAX_FIELD_LEN];
    int          tbl_nlen [MAX_ENTRIES];
    int          tbl_plen [MAX_ENTRIES];
    byte unsigned rq_name [MAX_FIELD_LEN];
    byte unsigned rq_pass [MAX_FIELD_LEN];
    int          rq_nlen;
    int          rq_plen;

    verdict_t    verdict_q[$];
    int          errors;
    int          items_sent;
    int          requests_sent;
    int          verdicts_seen;
    int          table_full_hits;
    bit          calm;
    bit          hold_sink;
    bit          typed_valid;
    verdict_t    typed_verdict;

    function automatic bit field_ok(input int len);
        return len > 0 && len <= MAX_FIELD_LEN;
    endfunction

    function automatic int find_slot();
        bit same;
        for (int s = 0; s < MAX_ENTRIES; s++) begin
            if (tbl_used[s] && tbl_nlen[s] == rq_nlen) begin
                same = 1'b1;
                for (int j = 0; j < rq_nlen; j++)
                    if (tbl_name[s][j] != rq_name[j]) same = 1'b0;
                if (same) return s;
            end
        end
        return -1;
    endfunction

    function automatic int used_slots();
        int n;
        n = 0;
        foreach (tbl_used[s]) n += tbl_used[s];
        return n;
    endfunction

    function automatic void append_to(inout byte unsigned buf_[MAX_FIELD_LEN],
                                      inout int len, input byte unsigned b);
        if (len < MAX_FIELD_LEN) begin
            buf_[len] = b;
            len++;
        end else begin
            len = MAX_FIELD_LEN + 1;
        end
    endfunction

    // Advances the table model by one accepted transfer; fires when a request ends.
    function automatic bit table_step(input req_item_t it, output verdict_t v);
        int  s;
        bit  ok;
        bit  same;
        if (it.has_byte) begin
            if (!it.part) append_to(rq_name, rq_nlen, it.data);
            else          append_to(rq_pass, rq_plen, it.data);
        end
        if (!it.eof) return 1'b0;
        if (!it.part && it.func != FUNC_REMOVE) return 1'b0;
        ok = 1'b0;
        case (it.func)
            FUNC_VALIDATE: begin
                if (field_ok(rq_nlen) && field_ok(rq_plen)) begin
                    s = find_slot();
                    if (s >= 0 && tbl_plen[s] == rq_plen) begin
                        same = 1'b1;
                        for (int j = 0; j < rq_plen; j++)
                            if (tbl_pass[s][j] != rq_pass[j]) same = 1'b0;
                        ok = same;
                    end
                end
            end
            FUNC_ADD: begin
                if (field_ok(rq_nlen) && field_ok(rq_plen) && find_slot() < 0) begin
                    if (used_slots() == MAX_ENTRIES) table_full_hits++;
                    for (int i = 0; i < MAX_ENTRIES && !ok; i++) begin
                        if (!tbl_used[i]) begin
                            tbl_used[i] = 1'b1;
                            for (int j = 0; j < MAX_FIELD_LEN; j++) begin
                                tbl_name[i][j] = (j < rq_nlen) ? rq_name[j] : 8'h00;
                                tbl_pass[i][j] = (j < rq_plen) ? rq_pass[j] : 8'h00;
                            end
                            tbl_nlen[i] = rq_nlen;
                            tbl_plen[i] = rq_plen;
                            ok = 1'b1;
                        end
                    end
                end
            end
            FUNC_REMOVE: begin
                if (field_ok(rq_nlen)) begin
                    s = find_slot();
                    if (s >= 0) begin
                        tbl_used[s] = 1'b0;
                        tbl_nlen[s] = 0;
                        tbl_plen[s] = 0;
                        for (int j = 0; j < MAX_FIELD_LEN; j++) begin
                            tbl_name[s][j] = 8'h00;
                            tbl_pass[s][j] = 8'h00;
                        end
                        ok = 1'b1;
                    end
                end
            end
            default: ok = 1'b0;
        endcase
        rq_nlen = 0;
        rq_plen = 0;
        v.ok    = ok;
        v.count = 5'(used_slots());
        return 1'b1;
    endfunction

    initial begin
        foreach (tbl_used[s]) begin
            tbl_used[s] = 1'b0;
            tbl_nlen[s] = 0;
            tbl_plen[s] = 0;
            for (int j = 0; j < MAX_FIELD_LEN; j++) begin
                tbl_name[s][j] = 8'h00;
                tbl_pass[s][j] = 8'h00;
            end
        end
        tbl_used[0] = 1'b1;
        tbl_nlen[0] = 5;
        tbl_plen[0] = 5;
        for (int j = 0; j < 5; j++) begin
            tbl_name[0][j] = def_byte(IDX_W'(j));
            tbl_pass[0][j] = def_byte(IDX_W'(j));
        end
        rq_nlen = 0;
        rq_plen = 0;
    end

    // One transfer on the input side; sampling at the falling edge keeps it race free.
    task automatic send_item(input req_item_t it);
        verdict_t v;
        if (!calm && $urandom_range(0, 99) < 25) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.data;
        s_axis_tuser  <= {it.has_byte, it.part, it.func};
        s_axis_tlast  <= it.eof;
        @(negedge aclk);
        while (!s_axis_tready) @(negedge aclk);
        if (table_step(it, v)) begin
            verdict_q.push_back(typed_valid ? typed_verdict : v);
            typed_valid = 1'b0;
        end
        items_sent++;
        @(posedge aclk);
    endtask

    task automatic send_field(input func_t f, input bit part, input bytes_q b);
        req_item_t it;
        it.func = f;
        it.part = part;
        if (b.size() == 0) begin
            it.data     = 8'($urandom);
            it.has_byte = 1'b0;
            it.eof      = 1'b1;
            send_item(it);
        end
        foreach (b[k]) begin
            it.data     = b[k];
            it.has_byte = 1'b1;
            it.eof      = (k == b.size() - 1);
            send_item(it);
            // an empty item in the middle of a field must change nothing
            if (!it.eof && $urandom_range(0, 29) == 0) begin
                it.has_byte = 1'b0;
                send_item(it);
            end
        end
    endtask

    task automatic send_request(input func_t f, input bytes_q nm, input bytes_q pw,
                                input bit split);
        bytes_q head;
        requests_sent++;
        if (split && nm.size() > 1 && f != FUNC_REMOVE) begin
            head = nm[0:nm.size()/2-1];
            nm   = nm[nm.size()/2:$];
            send_field(f, 1'b0, head);
        end
        send_field(f, 1'b0, nm);
        if (f != FUNC_REMOVE) send_field(f, 1'b1, pw);
    endtask

    function automatic bytes_q to_bytes(input string s, input int fill_len, input byte fill);
        bytes_q q;
        if (fill_len > 0) begin
            for (int k = 0; k < fill_len; k++) q.push_back(fill);
        end else begin
            for (int k = 0; k < s.len(); k++) q.push_back(s[k]);
        end
        return q;
    endfunction

    function automatic bytes_q random_name();
        bytes_q q;
        int     n;
        int     pick;
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) q.push_back(8'h61 + 8'($urandom_range(0, 3)));
        end else if (pick < 98) begin
            n = $urandom_range(1, 12);
            for (int k = 0; k < n; k++) q.push_back(8'($urandom));
        end else if (pick < 99) begin
            n = $urandom_range(MAX_FIELD_LEN + 1, MAX_FIELD_LEN + 4);
            for (int k = 0; k < n; k++) q.push_back(8'($urandom));
        end
        return q;
    endfunction

    dir_row_t dir_rows[] = '{
        '{FUNC_VALIDATE, "admin", "admin", 0, 0, 0, 0, 0, 1, 1},
        '{FUNC_VALIDATE, "admin", "admim", 0, 0, 0, 0, 0, 0, 1},
        '{FUNC_VALIDATE, "",      "admin", 0, 0, 0, 0, 0, 0, 1},
        '{FUNC_VALIDATE, "admin", "",      0, 0, 0, 0, 0, 0, 1},
        '{FUNC_ADD,      "bob",   "x",     0, 0, 0, 0, 0, 1, 2},
        '{FUNC_ADD,      "bob",   "y",     0, 0, 0, 0, 0, 0, 2},
        '{FUNC_VALIDATE, "bob",   "x",     0, 0, 0, 0, 0, 1, 2},
        '{FUNC_RSVD,     "bob",   "x",     0, 0, 0, 0, 0, 0, 2},
        '{FUNC_ADD,      "ann",   "",      0, 0, 0, 0, 0, 0, 2},
        '{FUNC_REMOVE,   "bob",   "",      0, 0, 0, 0, 0, 1, 1},
        '{FUNC_REMOVE,   "bob",   "",      0, 0, 0, 0, 0, 0, 1},
        '{FUNC_REMOVE,   "",      "",      0, 0, 0, 0, 0, 0, 1},
        '{FUNC_REMOVE,   "",      "",      256, 8'h41, 0, 0, 0, 0, 1},
        '{FUNC_ADD,      "q",     "",      0, 0, 255, 8'h00, 0, 1, 2},
        '{FUNC_VALIDATE, "q",     "",      0, 0, 1, 8'h00, 0, 0, 2},
        '{FUNC_REMOVE,   "q",     "",      0, 0, 0, 0, 0, 1, 1},
        '{FUNC_VALIDATE, "admin", "admin", 0, 0, 0, 0, 1, -1, 0},
        '{FUNC_ADD,      "ad",    "min",   0, 0, 0, 0, 1, -1, 0},
        '{FUNC_REMOVE,   "admin", "",      0, 0, 0, 0, 0, 1, 1},
        '{FUNC_ADD,      "z",     "",      0, 0, 1, 8'h00, 0, 1, 2}
    };

    initial begin
        func_t       f;
        bytes_q      nm;
        bytes_q      pw;
        int          s;
        int          base;
        bit          paused;
        bit          held;
        req_item_t   noise;
        errors          = 0;
        items_sent      = 0;
        requests_sent   = 0;
        verdicts_seen   = 0;
        table_full_hits = 0;
        calm            = 1'b0;
        hold_sink       = 1'b0;
        typed_valid     = 1'b0;
        paused          = 1'b0;
        held            = 1'b0;
        aresetn         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = 8'h00;
        s_axis_tuser    = 4'h0;
        s_axis_tlast    = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[r]) begin
            nm = to_bytes(dir_rows[r].name, dir_rows[r].name_fill_len, dir_rows[r].name_fill);
            pw = to_bytes(dir_rows[r].pass, dir_rows[r].pass_fill_len, dir_rows[r].pass_fill);
            typed_valid = (dir_rows[r].exp_ok >= 0);
            typed_verdict.ok    = dir_rows[r].exp_ok[0];
            typed_verdict.count = 5'(dir_rows[r].exp_count);
            send_request(dir_rows[r].func, nm, pw, dir_rows[r].split_name);
            typed_valid = 1'b0;
        end

        base = items_sent;
        while (items_sent < base + 140) begin
            calm = (items_sent > base + 20 && items_sent < base + 70);
            if (items_sent > base + 80 && !held) begin
                held      = 1'b1;
                hold_sink = 1'b1;
            end
            if (items_sent > base + 110 && !paused) begin
                paused = 1'b1;
                s_axis_tvalid <= 1'b0;
                while (verdict_q.size() != 0) @(posedge aclk);
            end
            if ($urandom_range(0, 99) < 6) begin
                noise = req_item_t'(13'($urandom));
                send_item(noise);
                continue;
            end
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7: f = FUNC_ADD;
                8, 9, 10, 11, 12, 13:   f = FUNC_VALIDATE;
                14, 15, 16, 17, 18:     f = FUNC_REMOVE;
                default:                f = FUNC_RSVD;
            endcase
            nm = random_name();
            pw = random_name();
            // half the lookups pick a slot and, if it is used, reuse its stored pair so matches happen often
            if (f != FUNC_ADD && $urandom_range(0, 1)) begin
                s = $urandom_range(0, MAX_ENTRIES - 1);
                if (tbl_used[s]) begin
                    nm.delete();
                    pw.delete();
                    for (int j = 0; j < tbl_nlen[s]; j++) nm.push_back(tbl_name[s][j]);
                    for (int j = 0; j < tbl_plen[s]; j++) pw.push_back(tbl_pass[s][j]);
                    if ($urandom_range(0, 3) == 0 && pw.size() > 0)
                        pw[pw.size()-1] ^= 8'(1 << $urandom_range(0, 7));
                end
            end
            send_request(f, nm, pw, $urandom_range(0, 9) == 0);
        end
        s_axis_tvalid <= 1'b0;

        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (verdict_q.size() != 0 || m_axis_tvalid) begin
            errors++;
            $display("%0t: expected no pending result, actual %0d queued, tvalid %0b",
                     $time, verdict_q.size(), m_axis_tvalid);
        end
        $display("covered %0d requests in %0d transfers, %0d results checked",
                 requests_sent, items_sent, verdicts_seen);
        $display("adds against a full table: %0d, admin slot removed and reused", table_full_hits);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // result side: random backpressure plus one long hold-off
    initial begin
        m_axis_tready = 1'b0;
        @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                m_axis_tready <= 1'b0;
                repeat (3000) @(posedge aclk);
                hold_sink = 1'b0;
            end
            m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 25);
        end
    end

    always @(negedge aclk) begin
        verdict_t got;
        verdict_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.ok    = m_axis_tdata[0];
            got.count = m_axis_tdata[5:1];
            verdicts_seen++;
            if (verdict_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result ok=%0b count=%0d", $time, got.ok, got.count);
            end else begin
                want = verdict_q.pop_front();
                if (got.ok != want.ok) begin
                    errors++;
                    $display("%0t: ok expected %0b actual %0b", $time, want.ok, got.ok);
                end
                if (got.count != want.count) begin
                    errors++;
                    $display("%0t: user_count expected %0d actual %0d",
                             $time, want.count, got.count);
                end
                if (m_axis_tdata[7:6] != 2'b00) begin
                    errors++;
                    $display("%0t: pad bits expected 0 actual %0b", $time, m_axis_tdata[7:6]);
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
